// File: src/assert_macros.svh
// Assertion macros used by the scheduler datapath.
// Needs clk in the scope of each use, and rst_n as well for ASSERT_CLK.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/elsch_pkg.sv
// Package for the elevator scheduler: sizes, codes, FSM state and control structs.
// No dependencies.
package elsch_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int FLOOR_BITS  = 6;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int CFG_IDX_W   = PADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_FLOOR = '0;

    localparam logic [1:0] DIR_IDLE = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_BAD  = 2'b10;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_DIR = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic OP_CALL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALL,
        ST_PREP,
        ST_SCAN,
        ST_DECIDE,
        ST_REMOVE,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic do_call;
        logic do_prep;
        logic do_scan;
        logic do_decide;
        logic do_remove;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_is_call;
        logic both_empty;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: src/elsch_ifs.sv
// Valid/ready channel interfaces for call/tick items and result items.
// Depends on elsch_pkg.
interface elsch_req_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [elsch_pkg::FLOOR_BITS-1:0]    requested_floor;
    logic signed [1:0]                   call_direction;

    modport source (output valid, output op, output requested_floor,
                    output call_direction, input ready);
    modport sink   (input valid, input op, input requested_floor,
                    input call_direction, output ready);
endinterface

interface elsch_res_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [elsch_pkg::FLOOR_BITS-1:0]    car_floor;
    logic signed [1:0]                   travel_direction;
    logic                                arrived;
    logic [elsch_pkg::FLOOR_BITS-1:0]    arrived_floor;

    modport source (output valid, output status, output car_floor,
                    output travel_direction, output arrived,
                    output arrived_floor, input ready);
    modport sink   (input valid, input status, input car_floor,
                    input travel_direction, input arrived,
                    input arrived_floor, output ready);
endinterface

// File: src/elevator_look_scheduler.sv
// Top level of the LOOK elevator scheduler: APB register, controller and datapath.
// Depends on elsch_pkg, elsch_ifs, elsch_ctrl and elsch_datapath.
//
//  channel   | kind        | contents
//  ----------+-------------+--------------------------------------------------
//  request   | valid/ready | op, requested_floor, call_direction
//  result    | valid/ready | status, car_floor, travel_direction, arrived,
//            |             | arrived_floor
//  apb       | APB write   | top_floor at byte address 0
//
// A call runs the call step and then loads the result; a tick runs prep, the head scan, decide and
// remove; the head scan reads the active queue over its RAM read port, one entry per cycle.
// A tick with both queues empty goes from prep straight to the result step.
// One transaction is in work at a time; a finished result waits in the output register while
// the next transaction is taken, and the last step stalls only while that register is full and result.ready is low.
// Reset is asynchronous and active low: car at floor 1, idle, both queues empty.
module elevator_look_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [elsch_pkg::PADDR_W-1:0]     paddr,
    input  logic [elsch_pkg::PDATA_W-1:0]     pwdata,
    output logic [elsch_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    elsch_req_if.sink                         request,
    elsch_res_if.source                       result
);

    localparam int FB = elsch_pkg::FLOOR_BITS;

    logic [FB-1:0]                   top_floor_reg;
    logic [elsch_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                            cfg_write;
    elsch_pkg::ctrl_cmd_t            cmd;
    elsch_pkg::dp_status_t           dp_status;
    logic                            in_ready;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[elsch_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_floor_reg <= FB'(1);
        end
        else if (cfg_write && (reg_idx == elsch_pkg::REG_TOP_FLOOR))
        begin
            top_floor_reg <= pwdata[FB-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == elsch_pkg::REG_TOP_FLOOR)
        begin
            prdata = {{(elsch_pkg::PDATA_W - FB){1'b0}}, top_floor_reg};
        end
    end

    assign request.ready = in_ready;

    elsch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .status   (dp_status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    elsch_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .top_floor (top_floor_reg),
        .cmd       (cmd),
        .status    (dp_status),
        .request   (request),
        .result    (result)
    );

endmodule

// File: src/elsch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module elsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/elsch_ctrl.sv
// Controller FSM of the scheduler: sequences call, prep, scan, decide, remove and result steps.
// Depends on elsch_pkg.
module elsch_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  elsch_pkg::dp_status_t status,
    output elsch_pkg::ctrl_cmd_t  cmd,
    output logic                  in_ready
);

    elsch_pkg::ctrl_state_t state_reg;
    elsch_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elsch_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            elsch_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.req_is_call ? elsch_pkg::ST_CALL
                                                    : elsch_pkg::ST_PREP;
                end
            end
            elsch_pkg::ST_CALL:   state_next = elsch_pkg::ST_DONE;
            elsch_pkg::ST_PREP:
            begin
                state_next = status.both_empty ? elsch_pkg::ST_DONE
                                               : elsch_pkg::ST_SCAN;
            end
            elsch_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = elsch_pkg::ST_DECIDE;
                end
            end
            elsch_pkg::ST_DECIDE: state_next = elsch_pkg::ST_REMOVE;
            elsch_pkg::ST_REMOVE: state_next = elsch_pkg::ST_DONE;
            elsch_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = elsch_pkg::ST_IDLE;
                end
            end
            default:              state_next = elsch_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            elsch_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            elsch_pkg::ST_CALL:   cmd.do_call   = 1'b1;
            elsch_pkg::ST_PREP:   cmd.do_prep   = 1'b1;
            elsch_pkg::ST_SCAN:   cmd.do_scan   = 1'b1;
            elsch_pkg::ST_DECIDE: cmd.do_decide = 1'b1;
            elsch_pkg::ST_REMOVE: cmd.do_remove = 1'b1;
            elsch_pkg::ST_DONE:   cmd.out_load  = status.out_free;
            default:              cmd           = '0;
        endcase
    end

endmodule

// File: src/elsch_datapath.sv
// Datapath of the scheduler: car state, two request queues in RAM, head scan and result register.
// Depends on elsch_pkg, elsch_ifs, elsch_ram and assert_macros.svh.
`include "assert_macros.svh"

module elsch_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [elsch_pkg::FLOOR_BITS-1:0]   top_floor,
    input  elsch_pkg::ctrl_cmd_t               cmd,
    output elsch_pkg::dp_status_t              status,
    elsch_req_if.sink                          request,
    elsch_res_if.source                        result
);

    localparam int FB = elsch_pkg::FLOOR_BITS;
    localparam int CW = elsch_pkg::CNT_W;
    localparam int IW = elsch_pkg::IDX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(elsch_pkg::QUEUE_DEPTH);

    logic          op_reg;
    logic [FB-1:0] floor_reg;
    logic [1:0]    dir_reg;

    logic [FB-1:0] car_reg, car_next;
    logic [1:0]    heading_reg, heading_next;
    logic [CW-1:0] up_cnt_reg, up_cnt_next;
    logic [CW-1:0] dn_cnt_reg, dn_cnt_next;
    logic          up_sel_reg, up_sel_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [FB-1:0] best_val_reg, best_val_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic          rm_reg, rm_next;
    logic [1:0]    status_reg, status_next;
    logic          arr_reg, arr_next;
    logic [FB-1:0] arr_floor_reg, arr_floor_next;
    logic          out_valid_reg, out_valid_next;

    logic [1:0]    o_status_reg;
    logic [FB-1:0] o_car_reg;
    logic [1:0]    o_heading_reg;
    logic          o_arr_reg;
    logic [FB-1:0] o_arr_floor_reg;

    logic          up_we, dn_we;
    logic [IW-1:0] up_waddr, dn_waddr, raddr;
    logic [FB-1:0] up_wdata, dn_wdata, up_rdata, dn_rdata;

    logic [FB-1:0] top_eff;
    logic [CW-1:0] cnt_a, cnt_o;
    logic [CW-1:0] last_cnt;
    logic [FB-1:0] rd_a;
    logic          issue;
    logic          better;
    logic          behind;
    logic          dropped;
    logic [FB-1:0] new_car;
    logic [1:0]    h;
    logic          out_free;
    logic [4:0]    cmd_vec;

    elsch_ram #(.WIDTH(FB), .DEPTH(elsch_pkg::QUEUE_DEPTH)) u_up_ram (
        .clk   (clk),
        .we    (up_we),
        .waddr (up_waddr),
        .wdata (up_wdata),
        .raddr (raddr),
        .rdata (up_rdata)
    );

    elsch_ram #(.WIDTH(FB), .DEPTH(elsch_pkg::QUEUE_DEPTH)) u_dn_ram (
        .clk   (clk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .raddr (raddr),
        .rdata (dn_rdata)
    );

    assign top_eff  = (top_floor == '0) ? FB'(1) : top_floor;
    assign cnt_a    = up_sel_reg ? up_cnt_reg : dn_cnt_reg;
    assign cnt_o    = up_sel_reg ? dn_cnt_reg : up_cnt_reg;
    assign last_cnt = cnt_a - CW'(1);
    assign rd_a     = up_sel_reg ? up_rdata : dn_rdata;
    assign issue    = (idx_reg < cnt_a);
    assign better   = up_sel_reg ? (rd_a < best_val_reg) : (rd_a > best_val_reg);
    assign behind   = up_sel_reg ? (best_val_reg < car_reg) : (best_val_reg > car_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign cmd_vec  = {cmd.do_call, cmd.do_prep, cmd.do_scan, cmd.do_decide, cmd.do_remove};

    assign status.req_is_call = (request.op == elsch_pkg::OP_CALL);
    assign status.both_empty  = (up_cnt_reg == '0) && (dn_cnt_reg == '0);
    assign status.scan_done   = !issue && !pend_reg;
    assign status.out_free    = out_free;

    always_comb
    begin
        car_next       = car_reg;
        heading_next   = heading_reg;
        up_cnt_next    = up_cnt_reg;
        dn_cnt_next    = dn_cnt_reg;
        up_sel_next    = up_sel_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        rm_next        = rm_reg;
        status_next    = status_reg;
        arr_next       = arr_reg;
        arr_floor_next = arr_floor_reg;
        up_we          = 1'b0;
        dn_we          = 1'b0;
        up_waddr       = up_cnt_reg[IW-1:0];
        dn_waddr       = dn_cnt_reg[IW-1:0];
        up_wdata       = floor_reg;
        dn_wdata       = floor_reg;
        raddr          = idx_reg[IW-1:0];
        dropped        = 1'b0;
        new_car        = car_reg;
        h              = heading_reg;

        if (cmd.load)
        begin
            status_next    = elsch_pkg::STATUS_OK;
            arr_next       = 1'b0;
            arr_floor_next = '0;
        end

        if (cmd.do_call)
        begin
            if (dir_reg == elsch_pkg::DIR_BAD)
            begin
                status_next = elsch_pkg::STATUS_BAD_DIR;
            end
            else if (dir_reg == elsch_pkg::DIR_UP)
            begin
                if (up_cnt_reg >= DEPTH_C)
                begin
                    status_next = elsch_pkg::STATUS_FULL;
                end
                else
                begin
                    if (heading_reg == elsch_pkg::DIR_IDLE)
                    begin
                        heading_next = dir_reg;
                    end
                    up_we       = 1'b1;
                    up_cnt_next = up_cnt_reg + CW'(1);
                end
            end
            else
            begin
                if (dn_cnt_reg >= DEPTH_C)
                begin
                    status_next = elsch_pkg::STATUS_FULL;
                end
                else
                begin
                    if (heading_reg == elsch_pkg::DIR_IDLE)
                    begin
                        heading_next = dir_reg;
                    end
                    dn_we       = 1'b1;
                    dn_cnt_next = dn_cnt_reg + CW'(1);
                end
            end
        end

        if (cmd.do_prep)
        begin
            if ((up_cnt_reg == '0) && (dn_cnt_reg == '0))
            begin
                heading_next = elsch_pkg::DIR_IDLE;
            end
            else
            begin
                if (h == elsch_pkg::DIR_IDLE)
                begin
                    h = (up_cnt_reg != '0) ? elsch_pkg::DIR_UP : elsch_pkg::DIR_DOWN;
                end
                if ((h == elsch_pkg::DIR_UP) && (up_cnt_reg == '0))
                begin
                    h = elsch_pkg::DIR_DOWN;
                end
                else if ((h == elsch_pkg::DIR_DOWN) && (dn_cnt_reg == '0))
                begin
                    h = elsch_pkg::DIR_UP;
                end
                heading_next = h;
                up_sel_next  = (h == elsch_pkg::DIR_UP);
            end
            idx_next  = '0;
            pend_next = 1'b0;
        end

        if (cmd.do_scan)
        begin
            if (pend_reg && ((pend_idx_reg == '0) || better))
            begin
                best_val_next = rd_a;
                best_idx_next = pend_idx_reg;
            end
            pend_next     = issue;
            pend_idx_next = idx_reg[IW-1:0];
            if (issue)
            begin
                idx_next = idx_reg + CW'(1);
            end
        end

        if (cmd.do_decide)
        begin
            raddr   = last_cnt[IW-1:0];
            rm_next = 1'b0;
            if (behind)
            begin
                heading_next = up_sel_reg ? elsch_pkg::DIR_DOWN : elsch_pkg::DIR_UP;
                if (cnt_o < DEPTH_C)
                begin
                    rm_next = 1'b1;
                    if (up_sel_reg)
                    begin
                        dn_we       = 1'b1;
                        dn_wdata    = best_val_reg;
                        dn_cnt_next = dn_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        up_we       = 1'b1;
                        up_wdata    = best_val_reg;
                        up_cnt_next = up_cnt_reg + CW'(1);
                    end
                end
            end
            else
            begin
                if (best_val_reg != car_reg)
                begin
                    if (up_sel_reg)
                    begin
                        if (car_reg < top_eff)
                        begin
                            new_car = car_reg + FB'(1);
                        end
                        else
                        begin
                            dropped = 1'b1;
                        end
                    end
                    else
                    begin
                        if (car_reg > FB'(1))
                        begin
                            new_car = car_reg - FB'(1);
                        end
                        else
                        begin
                            dropped = 1'b1;
                        end
                    end
                end
                car_next = new_car;
                if (dropped)
                begin
                    rm_next = 1'b1;
                end
                else if (best_val_reg == new_car)
                begin
                    rm_next        = 1'b1;
                    arr_next       = 1'b1;
                    arr_floor_next = best_val_reg;
                end
            end
        end

        if (cmd.do_remove && rm_reg)
        begin
            if (up_sel_reg)
            begin
                up_we       = 1'b1;
                up_waddr    = best_idx_reg;
                up_wdata    = up_rdata;
                up_cnt_next = up_cnt_reg - CW'(1);
            end
            else
            begin
                dn_we       = 1'b1;
                dn_waddr    = best_idx_reg;
                dn_wdata    = dn_rdata;
                dn_cnt_next = dn_cnt_reg - CW'(1);
            end
            if ((cnt_a == CW'(1)) && (cnt_o == '0))
            begin
                heading_next = elsch_pkg::DIR_IDLE;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_reg       <= FB'(1);
            heading_reg   <= elsch_pkg::DIR_IDLE;
            up_cnt_reg    <= '0;
            dn_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            car_reg       <= car_next;
            heading_reg   <= heading_next;
            up_cnt_reg    <= up_cnt_next;
            dn_cnt_reg    <= dn_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= request.op;
            floor_reg <= request.requested_floor;
            dir_reg   <= request.call_direction;
        end
        up_sel_reg    <= up_sel_next;
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        best_val_reg  <= best_val_next;
        best_idx_reg  <= best_idx_next;
        rm_reg        <= rm_next;
        status_reg    <= status_next;
        arr_reg       <= arr_next;
        arr_floor_reg <= arr_floor_next;
        if (cmd.out_load)
        begin
            o_status_reg    <= (op_reg == elsch_pkg::OP_TICK) ? elsch_pkg::STATUS_OK
                                                               : status_reg;
            o_car_reg       <= car_reg;
            o_heading_reg   <= heading_reg;
            o_arr_reg       <= arr_reg;
            o_arr_floor_reg <= arr_floor_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = o_status_reg;
    assign result.car_floor        = o_car_reg;
    assign result.travel_direction = o_heading_reg;
    assign result.arrived          = o_arr_reg;
    assign result.arrived_floor    = o_arr_floor_reg;

    `ASSERT_ALWAYS(a_cnt_bound, (up_cnt_reg <= DEPTH_C) && (dn_cnt_reg <= DEPTH_C), "queue count beyond depth")
    `ASSERT_CLK(a_heading_code, heading_reg != elsch_pkg::DIR_BAD, "heading holds the bad code")
    `ASSERT_CLK(a_car_nonzero, car_reg != '0, "car at floor zero")
    `ASSERT_CLK(a_cmd_onehot, $onehot0(cmd_vec), "more than one datapath step at once")
    `ASSERT_CLK(a_decide_nonempty, cmd.do_decide |-> (cnt_a != '0), "head chosen from an empty queue")
    `ASSERT_CLK(a_out_load, cmd.out_load |=> out_valid_reg, "result lost on load")

endmodule

// File: test/elevator_look_scheduler_checker.sv
// Checker for the LOOK elevator scheduler: mirrors car and queue state, predicts each result.
// Watches the APB writes and both channels; depends on elsch_pkg and elsch_ifs.
module elevator_look_scheduler_checker
    import elsch_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    elsch_req_if                 request,
    elsch_res_if                 result,
    output int                   mismatches,
    output int                   awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]            status;
        logic [FLOOR_BITS-1:0] car_floor;
        logic [1:0]            travel;
        logic                  arrived;
        logic [FLOOR_BITS-1:0] arrived_floor;
    } car_report_t;

    car_report_t           awaited_reports[$];
    logic [FLOOR_BITS-1:0] top_floor_q;
    logic [FLOOR_BITS-1:0] car_pos;
    logic [1:0]            heading;
    logic [FLOOR_BITS-1:0] up_calls[QUEUE_DEPTH];
    logic [FLOOR_BITS-1:0] down_calls[QUEUE_DEPTH];
    int unsigned           up_cnt;
    int unsigned           down_cnt;

    task automatic drop_call(input bit from_up, input int unsigned idx);
        if (from_up) begin
            if (up_cnt != 0 && idx < up_cnt) begin
                up_calls[idx] = up_calls[up_cnt - 1];
                up_cnt--;
            end
        end else begin
            if (down_cnt != 0 && idx < down_cnt) begin
                down_calls[idx] = down_calls[down_cnt - 1];
                down_cnt--;
            end
        end
    endtask

    task automatic move_car(output logic hit, output logic [FLOOR_BITS-1:0] served);
        logic [FLOOR_BITS-1:0] lim;
        logic [FLOOR_BITS-1:0] head;
        bit                    going_up;
        bit                    dropped;
        int unsigned           best;
        hit = 1'b0;
        served = '0;
        lim = (top_floor_q == 0) ? FLOOR_BITS'(1) : top_floor_q;
        if (up_cnt == 0 && down_cnt == 0) begin
            heading = DIR_IDLE;
            return;
        end
        if (heading == DIR_IDLE)
            heading = (up_cnt != 0) ? DIR_UP : DIR_DOWN;
        if (heading == DIR_UP && up_cnt == 0)
            heading = DIR_DOWN;
        else if (heading == DIR_DOWN && down_cnt == 0)
            heading = DIR_UP;
        going_up = (heading == DIR_UP);
        best = 0;
        if (going_up) begin
            for (int k = 1; k < up_cnt; k++)
                if (up_calls[k] < up_calls[best])
                    best = k;
            head = up_calls[best];
        end else begin
            for (int k = 1; k < down_cnt; k++)
                if (down_calls[k] > down_calls[best])
                    best = k;
            head = down_calls[best];
        end
        if (going_up ? (head < car_pos) : (head > car_pos)) begin
            // hand the call behind the car over to the other queue if it has room, and turn round
            if (going_up) begin
                if (down_cnt < QUEUE_DEPTH) begin
                    down_calls[down_cnt] = head;
                    down_cnt++;
                    drop_call(1'b1, best);
                end
                heading = DIR_DOWN;
            end else begin
                if (up_cnt < QUEUE_DEPTH) begin
                    up_calls[up_cnt] = head;
                    up_cnt++;
                    drop_call(1'b0, best);
                end
                heading = DIR_UP;
            end
        end else begin
            dropped = 1'b0;
            if (head != car_pos) begin
                if (going_up) begin
                    if (car_pos < lim)
                        car_pos++;
                    else
                        dropped = 1'b1;
                end else begin
                    if (car_pos > 1)
                        car_pos--;
                    else
                        dropped = 1'b1;
                end
            end
            if (dropped) begin
                drop_call(going_up, best);
            end else if (head == car_pos) begin
                drop_call(going_up, best);
                hit = 1'b1;
                served = head;
            end
        end
        if (up_cnt == 0 && down_cnt == 0)
            heading = DIR_IDLE;
    endtask

    task automatic schedule_item(input logic op, input logic [FLOOR_BITS-1:0] floor,
                                 input logic [1:0] dir, output car_report_t rep);
        logic                  hit;
        logic [FLOOR_BITS-1:0] served;
        hit = 1'b0;
        served = '0;
        rep.status = STATUS_OK;
        if (op == OP_CALL) begin
            if (dir == DIR_BAD) begin
                rep.status = STATUS_BAD_DIR;
            end else if (dir == DIR_UP) begin
                if (up_cnt >= QUEUE_DEPTH) begin
                    rep.status = STATUS_FULL;
                end else begin
                    if (heading == DIR_IDLE)
                        heading = dir;
                    up_calls[up_cnt] = floor;
                    up_cnt++;
                end
            end else begin
                if (down_cnt >= QUEUE_DEPTH) begin
                    rep.status = STATUS_FULL;
                end else begin
                    if (heading == DIR_IDLE)
                        heading = dir;
                    down_calls[down_cnt] = floor;
                    down_cnt++;
                end
            end
        end else begin
            move_car(hit, served);
        end
        rep.car_floor = car_pos;
        rep.travel = heading;
        rep.arrived = hit;
        rep.arrived_floor = served;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        car_report_t want;
        car_report_t got;
        if (!rst_n) begin
            awaited_reports.delete();
            top_floor_q = FLOOR_BITS'(1);
            car_pos = FLOOR_BITS'(1);
            heading = DIR_IDLE;
            up_cnt = 0;
            down_cnt = 0;
            mismatches = 0;
            awaited = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_TOP_FLOOR)
                top_floor_q = pwdata[FLOOR_BITS-1:0];
            if (result.valid && result.ready) begin
                got.status = result.status;
                got.car_floor = result.car_floor;
                got.travel = result.travel_direction;
                got.arrived = result.arrived;
                got.arrived_floor = result.arrived_floor;
                if (awaited_reports.size() == 0) begin
                    $display("%0t: unexpected result status=%0d floor=%0d dir=%b arrived=%0d at=%0d",
                             $time, got.status, got.car_floor, got.travel, got.arrived,
                             got.arrived_floor);
                    mismatches++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected status=%0d floor=%0d dir=%b arrived=%0d at=%0d",
                                 $time, want.status, want.car_floor, want.travel, want.arrived,
                                 want.arrived_floor);
                        $display("%0t:   actual status=%0d floor=%0d dir=%b arrived=%0d at=%0d",
                                 $time, got.status, got.car_floor, got.travel, got.arrived,
                                 got.arrived_floor);
                        mismatches++;
                    end
                end
            end
            if (request.valid && request.ready) begin
                schedule_item(request.op, request.requested_floor, request.call_direction, want);
                awaited_reports.push_back(want);
            end
            awaited = awaited_reports.size();
        end
    end

endmodule

// File: test/elevator_look_scheduler_tb.sv
// Testbench top for the LOOK elevator scheduler: clock, reset, APB writes and call/tick traffic.
// Depends on elsch_pkg, elsch_ifs, elevator_look_scheduler and the scheduler checker.
module elevator_look_scheduler_tb;
    import elsch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS      = 40;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 mismatches;
    int                 awaited;
    bit                 calm = 1'b0;
    bit                 long_hold = 1'b0;

    elsch_req_if req_ch();
    elsch_res_if res_ch();

    elevator_look_scheduler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (req_ch),
        .result  (res_ch)
    );

    elevator_look_scheduler_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .request    (req_ch),
        .result     (res_ch),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_top_floor(input logic [FLOOR_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TOP_FLOOR, 2'b00};
        pwdata <= {{(PDATA_W - FLOOR_BITS){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic offer(input logic op, input logic [FLOOR_BITS-1:0] floor,
                         input logic [1:0] dir);
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.requested_floor <= floor;
        req_ch.call_direction <= dir;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic settle;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_traffic(input int count, input logic [FLOOR_BITS-1:0] top,
                                  input bit with_hold);
        logic [FLOOR_BITS-1:0] reach;
        logic [FLOOR_BITS-1:0] floor;
        logic [1:0]            dir;
        int                    pick;
        reach = (top == 0) ? FLOOR_BITS'(1) : top;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == 20)
                long_hold = 1'b1;
            if ($urandom_range(0, 1) == 0)
            begin
                offer(OP_TICK, FLOOR_BITS'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    floor = FLOOR_BITS'($urandom_range(1, reach));
                else if (pick < 9)
                    floor = FLOOR_BITS'($urandom_range(0, 63));
                else
                    floor = $urandom_range(0, 1) ? FLOOR_BITS'(63) : FLOOR_BITS'(0);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    dir = DIR_BAD;
                else if (pick < 4)
                    dir = DIR_IDLE;
                else
                    dir = (pick < 12) ? DIR_UP : DIR_DOWN;
                offer(OP_CALL, floor, dir);
            end
        end
    endtask

    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (hold_left != 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left = $urandom_range(0, 18);
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [FLOOR_BITS-1:0] phase_tops[5];
        phase_tops[0] = FLOOR_BITS'(0);
        phase_tops[1] = FLOOR_BITS'(63);
        phase_tops[2] = FLOOR_BITS'(1);
        phase_tops[3] = FLOOR_BITS'(20);
        phase_tops[4] = FLOOR_BITS'($urandom_range(2, 62));
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.op <= OP_CALL;
        req_ch.requested_floor <= '0;
        req_ch.call_direction <= DIR_IDLE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_top_floor(FLOOR_BITS'(63));
        offer(OP_TICK, '0, DIR_IDLE);
        offer(OP_CALL, '0, DIR_BAD);
        offer(OP_CALL, FLOOR_BITS'(1), DIR_IDLE);
        offer(OP_TICK, '0, DIR_IDLE);
        // fill the upward queue past its depth, low floors behind the car included
        for (int k = 0; k < 17; k++)
            offer(OP_CALL, FLOOR_BITS'((k * 23) % 64), DIR_UP);
        offer(OP_CALL, FLOOR_BITS'(63), DIR_DOWN);
        repeat (3)
            offer(OP_TICK, FLOOR_BITS'(63), DIR_DOWN);
        settle();

        for (int p = 0; p < 5; p++)
        begin
            write_top_floor(phase_tops[p]);
            if (p == 4)
                calm = 1'b1;
            random_traffic(PHASE_ITEMS, phase_tops[p], p == 1);
            // let the car run out its queues before the next setting
            repeat (40)
                offer(OP_TICK, '0, DIR_IDLE);
            settle();
        end

        if (mismatches == 0 && awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/elsch_pkg.sv
src/elsch_ifs.sv
src/elsch_ram.sv
src/elsch_ctrl.sv
src/elsch_datapath.sv
src/elevator_look_scheduler.sv
test/elevator_look_scheduler_checker.sv
test/elevator_look_scheduler_tb.sv
